// File: rtl/wtc_pkg.sv
package wtc_pkg;

  localparam int KW_NUM     = 18;
  localparam int KW_MAX_LEN = 8;

  localparam logic [7:0] SPACE_CODE = 8'd32;

  localparam logic [4:0] CLASS_NUMBER  = 5'd18;
  localparam logic [4:0] CLASS_IDENT   = 5'd19;
  localparam logic [4:0] CLASS_ILLEGAL = 5'd20;

  // keyword spellings, padded with nul beyond their length
  localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
    '{"P", "R", "I", "N", "T", 8'h00, 8'h00, 8'h00},
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "C", "H", "O", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"V", "A", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "R", "R", "A", "Y", 8'h00, 8'h00, 8'h00},
    '{"D", "E", "V", "I", "A", "T", "E", 8'h00},
    '{"V", "A", "R", "I", "A", "N", "C", "E"},
    '{"T", "O", "T", "A", "L", 8'h00, 8'h00, 8'h00},
    '{"R", "A", "N", "G", "E", 8'h00, 8'h00, 8'h00},
    '{"M", "E", "A", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "E", "D", "I", "A", "N", 8'h00, 8'h00},
    '{"M", "O", "D", "E", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "D", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "U", "L", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "U", "B", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "I", "V", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "S", "H", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd5, 4'd3, 4'd4, 4'd3, 4'd5, 4'd7, 4'd8, 4'd5, 4'd5,
    4'd4, 4'd6, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd4
  };

  typedef struct packed {
    logic [4:0] token_class;
    logic [9:0] token_start;
    logic [7:0] token_length;
    logic       length_saturated;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = is_digit(c) || ((c >= 8'd65) && (c <= 8'd90)) ||
               ((c >= 8'd97) && (c <= 8'd122));
  endfunction

endpackage

// File: rtl/wtc_if.sv
interface wtc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface wtc_token_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_class;
  logic [9:0] token_start;
  logic [7:0] token_length;
  logic       length_saturated;

  modport source (output valid, output token_class, output token_start,
                  output token_length, output length_saturated, input ready);
  modport sink   (input valid, input token_class, input token_start,
                  input token_length, input length_saturated, output ready);
endinterface

// File: rtl/word_token_classifier_top.sv
// channel | dir | payload                                              | role
// in_ch   | in  | char_code[7:0], end_of_line                           | one char a request
// out_ch  | out | token_class[4:0], token_start[9:0], token_length[7:0], | one word a request
//         |     | length_saturated                                     |
//
// one char accepted every cycle while in_ch.ready is high; its word state is updated in the same cycle
// a finished word is registered in the output buffer and shown on out_ch after the closing space or last char
// the rate is set by the combinational keyword match and class select in wtc_scan
// synchronous active-low reset clears the word state, line position and buffer
// a two-entry output buffer lets input flow while a result waits; in_ch stalls
// only when both entries hold results
module word_token_classifier_top #(
  parameter int MAX_LINE = 1024,
  parameter int MAX_WORD = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  wtc_char_if.sink    in_ch,
  wtc_token_if.source out_ch
);
  import wtc_pkg::*;

  logic   fire;      // char request taken this cycle
  logic   res_valid; // this char closes a word
  token_t res;
  logic   buf_full;

  // keep accepting until the skid entry is in use
  assign in_ch.ready = !buf_full;
  assign fire        = in_ch.valid && in_ch.ready;

  // word tracking, keyword candidates and classification
  wtc_scan #(
    .MAX_LINE (MAX_LINE),
    .MAX_WORD (MAX_WORD)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .char_code   (in_ch.char_code),
    .end_of_line (in_ch.end_of_line),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register plus skid entry
  wtc_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_ch    (out_ch)
  );

  // input only stalls behind a pending result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  // a word only closes at a space or at the last char
  a_close_cause: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> fire && ((in_ch.char_code == SPACE_CODE) || in_ch.end_of_line))
    else $error("word closed without a delimiter");

  // saturation flag goes with the clamped length
  a_sat_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.length_saturated) |-> (out_ch.token_length == 8'(MAX_WORD)))
    else $error("saturated word with unclamped length");

  // keywords are short and never saturated
  a_kw_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.token_class < CLASS_NUMBER)) |->
      (!out_ch.length_saturated && (out_ch.token_length >= 8'd2) &&
       (out_ch.token_length <= 8'd8)))
    else $error("keyword class with impossible length");

endmodule

// File: rtl/wtc_kw_match.sv
module wtc_kw_match (
  input  logic [7:0]               char_code,
  input  logic [2:0]               pos,
  input  logic                     pos_ovr,
  output logic [wtc_pkg::KW_NUM-1:0] keep
);
  import wtc_pkg::*;

  // a candidate survives when the keyword is long enough and the char matches
  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      keep[k] = !pos_ovr && ({1'b0, pos} < KW_LEN[k]) &&
                (KW_TEXT[k][pos] == char_code);
    end
  end

endmodule

// File: rtl/wtc_scan.sv
module wtc_scan #(
  parameter int MAX_LINE = 1024,
  parameter int MAX_WORD = 255
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      char_code,
  input  logic            end_of_line,
  output logic            res_valid,
  output wtc_pkg::token_t res
);
  import wtc_pkg::*;

  localparam int LP = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_WORD + 1);

  logic              in_word_r, in_word_nxt;
  logic [KW_NUM-1:0] cand_r;
  logic              all_digits_r, all_alnum_r, first_digit_r, sat_r;
  logic [LW-1:0]     word_len_r;
  logic [LP-1:0]     word_start_r, line_pos_r, line_pos_nxt;

  logic              is_space;
  logic [KW_NUM-1:0] cand_eff, cand_upd, kw_keep, fin_cand;
  logic              digits_eff, alnum_eff, first_eff, sat_eff;
  logic              digits_upd, alnum_upd, sat_upd;
  logic              fin_digits, fin_alnum, fin_first, fin_sat;
  logic [LW-1:0]     len_eff, len_upd, fin_len;
  logic [LP-1:0]     start_eff, fin_start;
  logic              len_room, kw_hit;
  logic [4:0]        kw_class, fin_class;

  assign is_space = (char_code == SPACE_CODE);

  // a new word starts from fresh flags
  assign cand_eff   = in_word_r ? cand_r        : {KW_NUM{1'b1}};
  assign digits_eff = in_word_r ? all_digits_r  : 1'b1;
  assign alnum_eff  = in_word_r ? all_alnum_r   : 1'b1;
  assign first_eff  = in_word_r ? first_digit_r : is_digit(char_code);
  assign sat_eff    = in_word_r ? sat_r         : 1'b0;
  assign len_eff    = in_word_r ? word_len_r    : '0;
  assign start_eff  = in_word_r ? word_start_r  : line_pos_r;

  wtc_kw_match u_kw (
    .char_code (char_code),
    .pos       (len_eff[2:0]),
    .pos_ovr   (|len_eff[LW-1:3]),
    .keep      (kw_keep)
  );

  assign cand_upd   = cand_eff & kw_keep;
  assign digits_upd = digits_eff & is_digit(char_code);
  assign alnum_upd  = alnum_eff & is_alnum(char_code);
  assign len_room   = (len_eff < LW'(MAX_WORD));
  assign len_upd    = len_room ? len_eff + 1'b1 : len_eff;
  assign sat_upd    = sat_eff | !len_room;

  // a space closes the stored word, a flagged last char closes the updated one
  assign fin_cand   = is_space ? cand_r        : cand_upd;
  assign fin_digits = is_space ? all_digits_r  : digits_upd;
  assign fin_alnum  = is_space ? all_alnum_r   : alnum_upd;
  assign fin_first  = is_space ? first_digit_r : first_eff;
  assign fin_sat    = is_space ? sat_r         : sat_upd;
  assign fin_len    = is_space ? word_len_r    : len_upd;
  assign fin_start  = is_space ? word_start_r  : start_eff;

  // lowest numbered keyword wins
  always_comb begin
    kw_hit   = 1'b0;
    kw_class = CLASS_ILLEGAL;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (fin_cand[k] && (fin_len == LW'(KW_LEN[k]))) begin
        kw_hit   = 1'b1;
        kw_class = 5'(k);
      end
    end
  end

  always_comb begin
    if (kw_hit && !fin_sat) begin
      fin_class = kw_class;
    end else if (fin_digits) begin
      fin_class = CLASS_NUMBER;
    end else if (fin_alnum && !fin_first) begin
      fin_class = CLASS_IDENT;
    end else begin
      fin_class = CLASS_ILLEGAL;
    end
  end

  assign res_valid            = fire && (is_space ? in_word_r : end_of_line);
  assign res.token_class      = fin_class;
  assign res.token_start      = 10'(fin_start);
  assign res.token_length     = 8'(fin_len);
  assign res.length_saturated = fin_sat;

  assign in_word_nxt  = !is_space && !end_of_line;
  assign line_pos_nxt = end_of_line ? '0 :
                        (line_pos_r < LP'(MAX_LINE - 1)) ? line_pos_r + 1'b1 : line_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r     <= 1'b0;
      cand_r        <= {KW_NUM{1'b1}};
      all_digits_r  <= 1'b1;
      all_alnum_r   <= 1'b1;
      first_digit_r <= 1'b0;
      word_len_r    <= '0;
      word_start_r  <= '0;
      line_pos_r    <= '0;
      sat_r         <= 1'b0;
    end else if (fire) begin
      in_word_r  <= in_word_nxt;
      line_pos_r <= line_pos_nxt;
      if (!is_space) begin
        cand_r        <= cand_upd;
        all_digits_r  <= digits_upd;
        all_alnum_r   <= alnum_upd;
        first_digit_r <= first_eff;
        word_len_r    <= len_upd;
        word_start_r  <= start_eff;
        sat_r         <= sat_upd;
      end
    end
  end

endmodule

// File: rtl/wtc_out_buf.sv
module wtc_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wtc_pkg::token_t push_data,
  output logic            full,
  wtc_token_if.source     out_ch
);
  import wtc_pkg::*;

  logic   out_valid_r, skid_valid_r;
  token_t out_data_r, skid_data_r;
  logic   pop;

  assign pop  = out_valid_r && out_ch.ready;
  assign full = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.token_class      = out_data_r.token_class;
  assign out_ch.token_start      = out_data_r.token_start;
  assign out_ch.token_length     = out_data_r.token_length;
  assign out_ch.length_saturated = out_data_r.length_saturated;

endmodule

// File: tb/sv/word_token_checker.sv
module word_token_checker #(
  parameter int MAX_LINE = 1024,
  parameter int MAX_WORD = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_eol,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [4:0] out_class,
  input  logic [9:0] out_start,
  input  logic [7:0] out_length,
  input  logic       out_saturated,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import wtc_pkg::*;

  localparam int NUM_KW = 18;

  // keyword spellings, index is the class code
  string kw_spell [NUM_KW] = '{
    "PRINT", "GET", "ECHO", "VAR", "ARRAY", "DEVIATE", "VARIANCE", "TOTAL", "RANGE",
    "MEAN", "MEDIAN", "MODE", "ADD", "MUL", "SUB", "DIV", "AT", "PUSH"
  };

  token_t pending_tokens [$];
  int     err_count = 0;

  // word scanner state
  bit              in_word;
  bit [NUM_KW-1:0] kw_alive;
  bit              digits_only;
  bit              alnum_only;
  bit              lead_digit;
  bit              too_long;
  int              word_len;
  int              word_pos;
  int              line_pos;

  function automatic bit char_is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic bit char_is_alnum(input logic [7:0] c);
    return char_is_digit(c) || (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic void clear_scanner();
    in_word     = 1'b0;
    kw_alive    = '1;
    digits_only = 1'b1;
    alnum_only  = 1'b1;
    lead_digit  = 1'b0;
    too_long    = 1'b0;
    word_len    = 0;
    word_pos    = 0;
    line_pos    = 0;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    int idx;
    idx = word_len;
    if (!in_word) begin
      in_word     = 1'b1;
      word_pos    = line_pos;
      kw_alive    = '1;
      digits_only = 1'b1;
      alnum_only  = 1'b1;
      lead_digit  = char_is_digit(c);
      word_len    = 0;
      too_long    = 1'b0;
      idx         = 0;
    end
    for (int k = 0; k < NUM_KW; k++) begin
      if (!(idx < kw_spell[k].len() && kw_spell[k][idx] == c))
        kw_alive[k] = 1'b0;
    end
    if (!char_is_digit(c))
      digits_only = 1'b0;
    if (!char_is_alnum(c))
      alnum_only = 1'b0;
    if (word_len < MAX_WORD)
      word_len++;
    else
      too_long = 1'b1;
  endfunction

  function automatic void close_word();
    token_t tok;
    bit     hit;
    hit = 1'b0;
    tok.token_class = CLASS_ILLEGAL;
    if (!in_word)
      return;
    // keywords win over everything, but never on an overlong word
    if (!too_long) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (!hit && kw_alive[k] && word_len == kw_spell[k].len()) begin
          tok.token_class = 5'(k);
          hit = 1'b1;
        end
      end
    end
    if (!hit) begin
      if (digits_only)
        tok.token_class = CLASS_NUMBER;
      else if (alnum_only && !lead_digit)
        tok.token_class = CLASS_IDENT;
      else
        tok.token_class = CLASS_ILLEGAL;
    end
    tok.token_start      = word_pos[9:0];
    tok.token_length     = word_len[7:0];
    tok.length_saturated = too_long;
    pending_tokens.insert(pending_tokens.size(), tok);
    in_word = 1'b0;
  endfunction

  function automatic void scan_char(input logic [7:0] c, input logic eol);
    if (c == SPACE_CODE) begin
      close_word();
    end else begin
      add_char(c);
      if (eol)
        close_word();
    end
    if (eol) begin
      in_word  = 1'b0;
      line_pos = 0;
    end else if (line_pos < MAX_LINE - 1) begin
      line_pos++;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      clear_scanner();
      pending_tokens.delete();
    end else begin
      if (in_valid && in_ready)
        scan_char(in_char, in_eol);
      if (out_valid && out_ready) begin
        if (pending_tokens.size() == 0) begin
          err_count++;
          $display("%0t ns: unexpected token, expected none, actual class %0d start %0d len %0d",
                   $time, out_class, out_start, out_length);
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_class", want.token_class, out_class);
          check_field("token_start", want.token_start, out_start);
          check_field("token_length", want.token_length, out_length);
          check_field("length_saturated", want.length_saturated, out_saturated);
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= pending_tokens.size();
  end

endmodule

// File: tb/sv/tb_word_token_classifier_top.sv
module tb_word_token_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wtc_pkg::*;

  localparam int LINE_CAP     = 1024;
  localparam int WORD_CAP     = 255;
  localparam int RANDOM_CHARS = 1300;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 2000;

  typedef enum int {
    W_KEYWORD,
    W_NEAR_KW,
    W_NUMBER,
    W_IDENT,
    W_DIGIT_LEAD,
    W_JUNK
  } word_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  wtc_char_if  char_if ();
  wtc_token_if tok_if ();

  int         mismatches;
  int         outstanding;
  int         chars_sent = 0;
  int         idle_pct   = 0;  // sender idle chance for the current line
  bit         quiet      = 1'b0;
  bit         hold_req   = 1'b0;
  logic [7:0] line_buf [$];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_token_classifier_top #(
    .MAX_LINE (LINE_CAP),
    .MAX_WORD (WORD_CAP)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_if),
    .out_ch (tok_if)
  );

  word_token_checker #(
    .MAX_LINE (LINE_CAP),
    .MAX_WORD (WORD_CAP)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (char_if.valid),
    .in_ready      (char_if.ready),
    .in_char       (char_if.char_code),
    .in_eol        (char_if.end_of_line),
    .out_valid     (tok_if.valid),
    .out_ready     (tok_if.ready),
    .out_class     (tok_if.token_class),
    .out_start     (tok_if.token_start),
    .out_length    (tok_if.token_length),
    .out_saturated (tok_if.length_saturated),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // ---------------------------------------------------------------------
  // character source
  // ---------------------------------------------------------------------

  // offer one character and hold it until the block takes the request
  task automatic push_char(input logic [7:0] c, input logic eol);
    int gap;
    if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 14);
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_if.valid       <= 1'b1;
    char_if.char_code   <= c;
    char_if.end_of_line <= eol;
    do @(posedge clk); while (!char_if.ready);
    chars_sent++;
  endtask

  // the last character of the buffer carries the line end flag
  task automatic send_line();
    foreach (line_buf[i])
      push_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      line_buf.insert(line_buf.size(), s[i]);
  endfunction

  function automatic void add_spaces(input int n);
    repeat (n) line_buf.insert(line_buf.size(), SPACE_CODE);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(48, 57)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_nonspace();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == SPACE_CODE);
    return c;
  endfunction

  function automatic word_kind_t random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return W_KEYWORD;
    if (r < 50) return W_NEAR_KW;
    if (r < 63) return W_NUMBER;
    if (r < 78) return W_IDENT;
    if (r < 86) return W_DIGIT_LEAD;
    return W_JUNK;
  endfunction

  // append one word; len is ignored for keyword-based kinds
  function automatic void add_word(input word_kind_t kind, input int len);
    int         k;
    int         kl;
    int         mode;
    logic [7:0] spelt [$];
    k  = $urandom_range(0, KW_NUM - 1);
    kl = KW_LEN[k];
    for (int i = 0; i < kl; i++)
      spelt.insert(spelt.size(), KW_TEXT[k][i]);
    case (kind)
      W_KEYWORD: begin
        line_buf = {line_buf, spelt};
      end
      W_NEAR_KW: begin
        // prefix, extension, lower-case letter or trailing digit
        mode = $urandom_range(0, 3);
        case (mode)
          0: void'(spelt.pop_back());
          1: spelt.insert(spelt.size(), rand_alnum());
          2: begin
            int p;
            p = $urandom_range(0, kl - 1);
            spelt[p] = spelt[p] + 8'd32;
          end
          default: spelt[kl-1] = 8'($urandom_range(48, 57));
        endcase
        line_buf = {line_buf, spelt};
      end
      W_NUMBER: begin
        repeat (len) line_buf.insert(line_buf.size(), 8'($urandom_range(48, 57)));
      end
      W_IDENT: begin
        line_buf.insert(line_buf.size(), rand_letter());
        repeat (len - 1) line_buf.insert(line_buf.size(), rand_alnum());
      end
      W_DIGIT_LEAD: begin
        line_buf.insert(line_buf.size(), 8'($urandom_range(48, 57)));
        repeat ((len < 2) ? 1 : len - 1) line_buf.insert(line_buf.size(), rand_letter());
      end
      default: begin
        repeat (len) line_buf.insert(line_buf.size(), rand_nonspace());
      end
    endcase
  endfunction

  // ordinary line: one to eight words, or sometimes only spaces
  task automatic random_line();
    int nwords;
    idle_pct = ($urandom_range(0, 9) < 3) ? 0 : 12;
    if ($urandom_range(0, 15) == 0) begin
      add_spaces($urandom_range(1, 3));
    end else begin
      nwords = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0)
        add_spaces($urandom_range(1, 2));
      for (int w = 0; w < nwords; w++) begin
        add_word(random_kind(), $urandom_range(1, 7));
        if (w < nwords - 1)
          add_spaces($urandom_range(1, 3));
      end
      // sometimes the line end lands on a trailing space
      if ($urandom_range(0, 3) == 0)
        add_spaces($urandom_range(1, 2));
    end
    send_line();
  endtask

  // overlong words around the length cap, then past the line position cap
  task automatic long_line();
    idle_pct = 12;
    add_word(W_IDENT, WORD_CAP);
    add_spaces(1);
    add_word(W_NUMBER, WORD_CAP + 1);
    add_spaces(1);
    add_word(W_JUNK, WORD_CAP + 45);
    add_spaces(2);
    while (line_buf.size() < LINE_CAP + 80) begin
      add_word(random_kind(), $urandom_range(1, 7));
      add_spaces($urandom_range(1, 2));
    end
    // last word starts well beyond the line position cap
    add_word(W_KEYWORD, 0);
    send_line();
  endtask

  // reset, directed lines, random lines, drain, verdict
  initial begin
    int stop_at;
    int waited;
    bit long_done;
    char_if.valid       <= 1'b0;
    char_if.char_code   <= 8'd0;
    char_if.end_of_line <= 1'b0;
    rst_n               <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // leading and repeated spaces, keyword, digit-led word, control chars,
    // line end flagged on a space
    add_text("  PUSH  9a ");
    line_buf.insert(line_buf.size(), 8'h00);
    line_buf.insert(line_buf.size(), 8'h7F);
    add_spaces(1);
    send_line();
    // letter and digit extremes, top-bit and low control chars, number at line end
    add_text("zZ09 ");
    line_buf.insert(line_buf.size(), 8'hFF);
    line_buf.insert(line_buf.size(), 8'h1F);
    add_text(" 09");
    send_line();
    // a lone space as the whole line
    add_spaces(1);
    send_line();
    // near miss on a keyword, then the shortest keyword at line end
    add_text("MEDIANS AT");
    send_line();

    // random part; the sink holds off for a long stretch right away
    hold_req  = 1'b1;
    stop_at   = chars_sent + RANDOM_CHARS;
    long_done = 1'b0;
    while (chars_sent < stop_at) begin
      if (chars_sent > stop_at - QUIET_TAIL)
        quiet = 1'b1;
      if (!long_done && chars_sent > stop_at - RANDOM_CHARS + 40) begin
        long_line();
        long_done = 1'b1;
        // a short stretch of ordinary lines still follows the long one
        stop_at   = chars_sent + QUIET_TAIL;
      end else begin
        random_line();
      end
    end
    quiet = 1'b1;
    char_if.valid <= 1'b0;

    // let every expected token come out, then idle before the verdict
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (outstanding != 0)
        $display("%0t ns: %0d expected tokens never arrived", $time, outstanding);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // token sink
  // ---------------------------------------------------------------------

  // random stall bursts, one long hold-off on request, none in the tail
  initial begin
    tok_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        tok_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        tok_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        tok_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
